@@ sv/stereo_peak_auto_ducker_macros.svh @@
// ---------------------------------------------------------------------------
// Stereo peak auto ducker assertion macros
// Shared same-cycle implication and next-cycle check forms.
// ---------------------------------------------------------------------------
`ifndef STEREO_PEAK_AUTO_DUCKER_MACROS_SVH
`define STEREO_PEAK_AUTO_DUCKER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPAD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("spad check failed");

// Consequent must hold in the cycle after the antecedent.
`define SPAD_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("spad check failed");

`endif

@@ sv/spad_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spad_pkg
// Widths, register indices, reset values and command types of the ducker.
// ---------------------------------------------------------------------------
package spad_pkg;

	localparam int SAMPLE_WIDTH_DEF = 24;

	localparam int Q23_W      = 24;
	localparam int COEF_W     = 25;
	localparam int GR_W       = 17;
	localparam int G_W        = 33;
	localparam int MUL_A_W    = 32;
	localparam int MUL_B_W    = 33;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int CFG_DATA_W = 32;
	localparam int REG_IDX_W  = 3;

	localparam logic [COEF_W-1:0] ONE_Q24 = COEF_W'(1) << 24;
	localparam logic [Q23_W-1:0]  ONE_Q23 = Q23_W'(1) << 23;
	localparam logic [GR_W-1:0]   ONE_Q16 = GR_W'(1) << 16;

	localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_OVER      = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ATTACK    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_RELEASE   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_DROP      = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_MIX       = 3'd5;

	localparam logic [23:0] RST_THRESHOLD = 24'd838861;
	localparam logic [31:0] RST_OVER      = 32'd72817;
	localparam logic [24:0] RST_ATTACK    = 25'd345770;
	localparam logic [24:0] RST_RELEASE   = 25'd1747;
	localparam logic [16:0] RST_DROP      = 17'd32768;
	localparam logic [16:0] RST_MIX       = 17'd65536;

	typedef struct packed {
		logic [23:0]       threshold_level;
		logic [31:0]       over_scale;
		logic [COEF_W-1:0] attack_coeff;
		logic [COEF_W-1:0] release_coeff;
		logic [GR_W-1:0]   drop_amount;
		logic [GR_W-1:0]   mix_amount;
	} cfg_t;

	typedef enum logic [4:0] {
		OP_IDLE,
		OP_DIFF_ENV,
		OP_MUL_ENV,
		OP_WB_ENV,
		OP_OVER,
		OP_MUL_OVER,
		OP_WB_RATIO,
		OP_MUL_TGT,
		OP_WB_TGT,
		OP_DIFF_GR,
		OP_MUL_GR,
		OP_WB_GR,
		OP_MUL_GAIN,
		OP_WB_GAIN,
		OP_MUL_L,
		OP_WB_L,
		OP_MUL_R,
		OP_WB_R
	} op_t;

	typedef struct packed {
		logic load;
		logic push;
		op_t  op;
	} cmd_t;

endpackage

@@ sv/spad_cfg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spad_cfg
// Configuration register bank, written through a plain indexed write port.
// ---------------------------------------------------------------------------
module spad_cfg
	import spad_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold_level <= RST_THRESHOLD;
			cfg_q.over_scale      <= RST_OVER;
			cfg_q.attack_coeff    <= RST_ATTACK;
			cfg_q.release_coeff   <= RST_RELEASE;
			cfg_q.drop_amount     <= RST_DROP;
			cfg_q.mix_amount      <= RST_MIX;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD: cfg_q.threshold_level <= cfg_wdata[23:0];
				REG_OVER:      cfg_q.over_scale      <= cfg_wdata[31:0];
				REG_ATTACK:    cfg_q.attack_coeff    <= cfg_wdata[COEF_W-1:0];
				REG_RELEASE:   cfg_q.release_coeff   <= cfg_wdata[COEF_W-1:0];
				REG_DROP:      cfg_q.drop_amount     <= cfg_wdata[GR_W-1:0];
				REG_MIX:       cfg_q.mix_amount      <= cfg_wdata[GR_W-1:0];
				default: begin
					// drop writes to unused indices
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ sv/spad_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spad_ctrl
// Sequencer: steps the datapath through its operations and owns the
// output valid flag.
// ---------------------------------------------------------------------------
`include "stereo_peak_auto_ducker_macros.svh"

module spad_ctrl
	import spad_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_PUSH
	} state_t;

	state_t state_q;
	op_t    op_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_PUSH && slot_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RUN;
						op_q    <= OP_DIFF_ENV;
					end
				end
				ST_RUN: begin
					if (op_q == OP_WB_R) begin
						state_q <= ST_PUSH;
						op_q    <= OP_IDLE;
					end else begin
						op_q <= op_t'(5'(op_q) + 5'd1);
					end
				end
				ST_PUSH: begin
					// hold the result until the output register can take it
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
					op_q    <= OP_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign cmd.load  = in_valid && (state_q == ST_IDLE);
	assign cmd.push  = (state_q == ST_PUSH) && slot_free;
	assign cmd.op    = op_q;

	`SPAD_ASSERT_NXT(a_load_starts_run, clk, arst_n, cmd.load, !in_ready && op_q == OP_DIFF_ENV)
	`SPAD_ASSERT_NXT(a_push_sets_valid, clk, arst_n, cmd.push, out_valid_q && in_ready)
	`SPAD_ASSERT_IMP(a_run_has_op, clk, arst_n, state_q == ST_RUN, op_q != OP_IDLE)

endmodule

@@ sv/spad_dp.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spad_dp
// Datapath: peak detect, two one-pole followers, overshoot scaling and the
// per-channel blend, all through one shared registered multiplier.
// ---------------------------------------------------------------------------
`include "stereo_peak_auto_ducker_macros.svh"

module spad_dp
	import spad_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	input  cfg_t                    cfg,
	input  logic [SAMPLE_WIDTH-1:0] left_sample,
	input  logic [SAMPLE_WIDTH-1:0] right_sample,
	output logic [SAMPLE_WIDTH-1:0] left_out,
	output logic [SAMPLE_WIDTH-1:0] right_out
);

	localparam int EXT_W = SAMPLE_WIDTH + 8;
	localparam int SHR   = (SAMPLE_WIDTH >= 24) ? SAMPLE_WIDTH - 24 : 0;
	localparam int SHL   = (SAMPLE_WIDTH >= 24) ? 0 : 24 - SAMPLE_WIDTH;
	localparam logic [PROD_W-1:0] RND_Q24 = PROD_W'(1) << 23;
	localparam logic [PROD_W-1:0] RND_Q32 = PROD_W'(1) << 31;
	localparam logic [SAMPLE_WIDTH-1:0] LIM = SAMPLE_WIDTH'(1) << (SAMPLE_WIDTH - 1);

	// state
	logic [Q23_W-1:0] env_q;
	logic [GR_W-1:0]  gr_q;

	// working registers
	logic [SAMPLE_WIDTH-1:0] mag_l_q, mag_r_q;
	logic                    neg_l_q, neg_r_q;
	logic [Q23_W-1:0]        peak_q, diff_q, over_q, ratio_q;
	logic [GR_W-1:0]         tgt_q;
	logic [COEF_W-1:0]       coef_q;
	logic                    rise_q, above_q;
	logic [G_W-1:0]          g_q;
	logic [PROD_W-1:0]       prod_q;
	logic [SAMPLE_WIDTH-1:0] res_l_q, res_r_q, out_l_q, out_r_q;

	// combinational
	logic [SAMPLE_WIDTH-1:0] mag_l, mag_r;
	logic [Q23_W-1:0]        q23_l, q23_r;
	logic [COEF_W-1:0]       atk_c, rel_c;
	logic [GR_W-1:0]         drop_c, mix_c;
	logic [MUL_A_W-1:0]      mul_a;
	logic [MUL_B_W-1:0]      mul_b;
	logic [PROD_W-1:0]       rnd_step;
	logic [Q23_W-1:0]        step;
	logic [PROD_W-17:0]      ratio_full;
	logic                    env_rise, gr_rise;

	function automatic logic [SAMPLE_WIDTH-1:0] abs_mag(logic [SAMPLE_WIDTH-1:0] raw);
		return raw[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(0) - raw : raw;
	endfunction

	function automatic logic [Q23_W-1:0] to_q23(logic [SAMPLE_WIDTH-1:0] mag);
		logic [EXT_W-1:0] ext;
		ext = EXT_W'(mag);
		ext = (ext << SHL) >> SHR;
		return ext[Q23_W-1:0];
	endfunction

	// round, drop the Q0.32 fraction, saturate and restore the sign
	function automatic logic [SAMPLE_WIDTH-1:0] finish(logic [PROD_W-1:0] p, logic neg);
		logic [PROD_W-1:0]       rnd;
		logic [SAMPLE_WIDTH-1:0] m;
		rnd = p + RND_Q32;
		m   = rnd[32 +: SAMPLE_WIDTH];
		if (neg) begin
			if (m > LIM)
				m = LIM;
			return SAMPLE_WIDTH'(0) - m;
		end
		if (m > LIM - SAMPLE_WIDTH'(1))
			m = LIM - SAMPLE_WIDTH'(1);
		return m;
	endfunction

	assign mag_l = abs_mag(left_sample);
	assign mag_r = abs_mag(right_sample);
	assign q23_l = to_q23(mag_l);
	assign q23_r = to_q23(mag_r);

	assign atk_c  = (cfg.attack_coeff > ONE_Q24) ? ONE_Q24 : cfg.attack_coeff;
	assign rel_c  = (cfg.release_coeff > ONE_Q24) ? ONE_Q24 : cfg.release_coeff;
	assign drop_c = (cfg.drop_amount > ONE_Q16) ? ONE_Q16 : cfg.drop_amount;
	assign mix_c  = (cfg.mix_amount > ONE_Q16) ? ONE_Q16 : cfg.mix_amount;

	assign env_rise = peak_q > env_q;
	assign gr_rise  = tgt_q > gr_q;

	assign rnd_step   = prod_q + RND_Q24;
	assign step       = rnd_step[24 +: Q23_W];
	assign ratio_full = prod_q[PROD_W-1:16];

	// operand selection for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_MUL_ENV, OP_MUL_GR: begin
				mul_a = MUL_A_W'(coef_q);
				mul_b = MUL_B_W'(diff_q);
			end
			OP_MUL_OVER: begin
				mul_a = cfg.over_scale;
				mul_b = MUL_B_W'(over_q);
			end
			OP_MUL_TGT: begin
				mul_a = MUL_A_W'(drop_c);
				mul_b = MUL_B_W'(ratio_q);
			end
			OP_MUL_GAIN: begin
				mul_a = MUL_A_W'(ONE_Q16 - ((gr_q > ONE_Q16) ? ONE_Q16 : gr_q));
				mul_b = MUL_B_W'(mix_c);
			end
			OP_MUL_L: begin
				mul_a = MUL_A_W'(mag_l_q);
				mul_b = g_q;
			end
			OP_MUL_R: begin
				mul_a = MUL_A_W'(mag_r_q);
				mul_b = g_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q <= '0;
			gr_q  <= '0;
		end else begin
			case (cmd.op)
				OP_WB_ENV: env_q <= rise_q ? env_q + step : env_q - step;
				OP_WB_GR:  gr_q  <= rise_q ? gr_q + GR_W'(step) : gr_q - GR_W'(step);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		if (cmd.load) begin
			mag_l_q <= mag_l;
			mag_r_q <= mag_r;
			neg_l_q <= left_sample[SAMPLE_WIDTH-1];
			neg_r_q <= right_sample[SAMPLE_WIDTH-1];
			peak_q  <= (q23_l > q23_r) ? q23_l : q23_r;
		end
		if (cmd.push) begin
			out_l_q <= res_l_q;
			out_r_q <= res_r_q;
		end
		case (cmd.op)
			OP_DIFF_ENV: begin
				rise_q <= env_rise;
				diff_q <= env_rise ? peak_q - env_q : env_q - peak_q;
				coef_q <= env_rise ? atk_c : rel_c;
			end
			OP_OVER: begin
				above_q <= env_q > cfg.threshold_level;
				over_q  <= env_q - cfg.threshold_level;
			end
			OP_WB_RATIO: begin
				if (!above_q)
					ratio_q <= '0;
				else if (ratio_full > (PROD_W - 16)'(ONE_Q23))
					ratio_q <= ONE_Q23;
				else
					ratio_q <= ratio_full[Q23_W-1:0];
			end
			OP_WB_TGT: tgt_q <= prod_q[23 +: GR_W];
			OP_DIFF_GR: begin
				rise_q <= gr_rise;
				diff_q <= Q23_W'(gr_rise ? tgt_q - gr_q : gr_q - tgt_q);
				coef_q <= gr_rise ? atk_c : rel_c;
			end
			OP_WB_GAIN: g_q <= G_W'({ONE_Q16 - mix_c, 16'd0}) + prod_q[G_W-1:0];
			OP_WB_L: res_l_q <= finish(prod_q, neg_l_q);
			OP_WB_R: res_r_q <= finish(prod_q, neg_r_q);
			default: begin
			end
		endcase
	end

	assign left_out  = out_l_q;
	assign right_out = out_r_q;

	`SPAD_ASSERT_IMP(a_env_in_range, clk, arst_n, 1'b1, env_q <= ONE_Q23)
	`SPAD_ASSERT_IMP(a_gr_in_range, clk, arst_n, 1'b1, gr_q <= ONE_Q16)
	`SPAD_ASSERT_NXT(a_env_release_falls, clk, arst_n, cmd.op == OP_WB_ENV && !rise_q, env_q <= $past(env_q))

endmodule

@@ sv/stereo_peak_auto_ducker.sv @@
`timescale 1ns / 1ps
// A stereo pair is accepted only while the sequencer is idle, and its result
// is pushed to the output register once the output side can take it; pairs
// are processed one at a time, as seven products share the single multiplier.
// A finished result waits in the output register while the next pair enters.
// Reset (arst_n low, asynchronous) clears envelope, gain reduction, control
// state and loads the default register values.
// ---------------------------------------------------------------------------
// stereo_peak_auto_ducker
// Stereo peak-following auto ducker with attack/release smoothing and mix.
// ---------------------------------------------------------------------------
module stereo_peak_auto_ducker
	import spad_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	localparam int TDATA_W = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [TDATA_W-1:0]    s_axis_tdata,  // left_sample, right_sample, zero pad
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [TDATA_W-1:0]    m_axis_tdata,  // left_out, right_out, zero pad
	input  logic                  cfg_we,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t                    cfg;
	cmd_t                    cmd;
	logic [SAMPLE_WIDTH-1:0] left_out, right_out;

	spad_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	spad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	spad_dp #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg          (cfg),
		.left_sample  (s_axis_tdata[SAMPLE_WIDTH-1:0]),
		.right_sample (s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
		.left_out     (left_out),
		.right_out    (right_out)
	);

	assign m_axis_tdata = TDATA_W'({right_out, left_out});

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the stereo peak auto ducker. Stereo pairs go in on
// the input stream and are run through a bit-exact software copy of the
// envelope, gain-reduction and mix arithmetic. Every word on the output
// stream is matched field by field against the oldest prediction. Register
// settings change only while the block is drained. Both stream sides idle
// at random, and two long output stalls fill the block.
// ---------------------------------------------------------------------------
module tb
	import spad_pkg::*;
;

	localparam int PAIR_W       = 2 * SAMPLE_WIDTH_DEF;
	localparam int QUIET_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE_TAIL  = 40;
	localparam int SEG_ITEMS    = 142;

	localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	typedef struct {
		logic [23:0] left_out;
		logic [23:0] right_out;
	} ducked_pair_t;

	class ducker_scoreboard;
		logic [23:0]       threshold_level;
		logic [31:0]       over_scale;
		logic [COEF_W-1:0] attack_coeff;
		logic [COEF_W-1:0] release_coeff;
		logic [GR_W-1:0]   drop_amount;
		logic [GR_W-1:0]   mix_amount;
		logic [Q23_W-1:0]  envelope;
		logic [GR_W-1:0]   reduction;
		ducked_pair_t      ducked_due[$];
		int                errors;

		function new();
			threshold_level = RST_THRESHOLD;
			over_scale      = RST_OVER;
			attack_coeff    = RST_ATTACK;
			release_coeff   = RST_RELEASE;
			drop_amount     = RST_DROP;
			mix_amount      = RST_MIX;
			envelope        = '0;
			reduction       = '0;
			errors          = 0;
		endfunction

		function void load_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
			case (idx)
				REG_THRESHOLD: threshold_level = value[23:0];
				REG_OVER:      over_scale      = value;
				REG_ATTACK:    attack_coeff    = value[COEF_W-1:0];
				REG_RELEASE:   release_coeff   = value[COEF_W-1:0];
				REG_DROP:      drop_amount     = value[GR_W-1:0];
				REG_MIX:       mix_amount      = value[GR_W-1:0];
				default: ;
			endcase
		endfunction

		// One-pole step towards the target; a coefficient above one jumps.
		function longint unsigned follow_toward(longint unsigned cur, longint unsigned tgt);
			bit rising;
			longint unsigned c, diff, step;
			rising = tgt > cur;
			c = rising ? attack_coeff : release_coeff;
			if (c > ONE_Q24)
				c = ONE_Q24;
			diff = rising ? tgt - cur : cur - tgt;
			step = (c * diff + 64'd8388608) >> 24;
			return rising ? cur + step : cur - step;
		endfunction

		function logic [23:0] scale_sample(logic [23:0] raw, longint unsigned g);
			bit neg;
			longint unsigned mag, m;
			neg = raw[23];
			mag = neg ? (64'd1 << 24) - raw : raw;
			m = (mag * g + 64'h8000_0000) >> 32;
			if (neg) begin
				if (m > ONE_Q23)
					m = ONE_Q23;
				return 24'((64'd1 << 24) - m);
			end
			if (m > ONE_Q23 - 1)
				m = ONE_Q23 - 1;
			return 24'(m);
		endfunction

		function void note_pair(logic [23:0] left, logic [23:0] right);
			longint unsigned mag_l, mag_r, peak, over, ratio, target;
			longint unsigned drop, mix, red, g;
			ducked_pair_t want;
			mag_l = left[23] ? (64'd1 << 24) - left : left;
			mag_r = right[23] ? (64'd1 << 24) - right : right;
			peak = (mag_l > mag_r) ? mag_l : mag_r;
			drop = (drop_amount > ONE_Q16) ? ONE_Q16 : drop_amount;
			mix  = (mix_amount > ONE_Q16) ? ONE_Q16 : mix_amount;
			envelope = Q23_W'(follow_toward(envelope, peak));
			target = 0;
			if (envelope > threshold_level) begin
				over = envelope - threshold_level;
				ratio = (over * over_scale) >> 16;
				if (ratio > ONE_Q23)
					ratio = ONE_Q23;
				target = (drop * ratio) >> 23;
			end
			reduction = GR_W'(follow_toward(reduction, target));
			red = (reduction > ONE_Q16) ? ONE_Q16 : reduction;
			g = ((ONE_Q16 - mix) << 16) + (ONE_Q16 - red) * mix;
			want.left_out  = scale_sample(left, g);
			want.right_out = scale_sample(right, g);
			ducked_due.push_back(want);
		endfunction

		function void check_ducked(logic [23:0] left, logic [23:0] right);
			ducked_pair_t want;
			if (ducked_due.size() == 0) begin
				$error("unexpected output word: left_out %h right_out %h", left, right);
				errors++;
				return;
			end
			want = ducked_due.pop_front();
			if (left !== want.left_out) begin
				$error("left_out: expected %h, got %h", want.left_out, left);
				errors++;
			end
			if (right !== want.right_out) begin
				$error("right_out: expected %h, got %h", want.right_out, right);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [PAIR_W-1:0]     s_axis_tdata = '0;  // left_sample, right_sample
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [PAIR_W-1:0]     m_axis_tdata;       // left_out, right_out
	logic                  cfg_we = 1'b0;
	logic [REG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	ducker_scoreboard sb = new();
	int src_idle_pct  = 0;
	int sink_idle_pct = 0;
	int hold_requests = 0;
	int quiet_cycles  = 0;

	stereo_peak_auto_ducker i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Output side: random back-pressure, plus a long hold when asked for.
	initial begin
		int hold_left;
		int holds_seen;
		hold_left  = 0;
		holds_seen = 0;
		forever begin
			@(negedge clk);
			if (holds_seen != hold_requests) begin
				holds_seen = hold_requests;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99, 0) >= sink_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_ducked(m_axis_tdata[23:0], m_axis_tdata[47:24]);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	task automatic send_pair(input logic [23:0] left, input logic [23:0] right);
		while ($urandom_range(99, 0) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {right, left};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_pair(left, right);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.load_reg(idx, value);
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.ducked_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Coefficients spread over many octaves so slow and fast followers both occur.
	function automatic logic [31:0] pick_coeff();
		if ($urandom_range(99, 0) < 15)
			return $urandom_range(32'h1FF_FFFF, 0);
		return $urandom_range(32'h100_0000, 0) >> $urandom_range(14, 0);
	endfunction

	function automatic logic [31:0] pick_amount();
		if ($urandom_range(99, 0) < 20)
			return $urandom_range(32'h1FFFF, 0);
		return $urandom_range(32'h10000, 0);
	endfunction

	task automatic pick_settings();
		logic [31:0] thr;
		longint unsigned scale;
		case ($urandom_range(9, 0))
			0:       thr = 0;
			1:       thr = $urandom_range(32'hFF_FFFF, 32'h80_0000);
			2, 3, 4: thr = $urandom_range(32'h3F_FFFF, 0);
			default: thr = $urandom_range(32'h7F_FFFF, 0);
		endcase
		if (thr < ONE_Q23 && $urandom_range(3, 0) != 0) begin
			// matching overshoot reciprocal, as software would load it
			scale = (64'd1 << 39) / (ONE_Q23 - thr);
			if (scale > 64'hFFFF_FFFF)
				scale = 64'hFFFF_FFFF;
		end else begin
			scale = $urandom();
		end
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_OVER, 32'(scale));
		write_reg(REG_ATTACK, pick_coeff());
		write_reg(REG_RELEASE, pick_coeff());
		write_reg(REG_DROP, pick_amount());
		write_reg(REG_MIX, pick_amount());
		if ($urandom_range(3, 0) == 0)
			write_reg($urandom_range(1, 0) ? REG_SPARE_A : REG_SPARE_B, $urandom());
	endtask

	// Bursts of roughly constant loudness, with some noise and full-scale hits.
	task automatic play_program(input int count);
		int burst_left;
		int amp;
		int mag;
		int pick;
		logic [23:0] left;
		logic [23:0] right;
		burst_left = 0;
		amp = 0;
		for (int i = 0; i < count; i++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(40, 4);
				amp = $urandom_range(32'h80_0000, 0) >> $urandom_range(10, 0);
			end
			burst_left--;
			pick = $urandom_range(99, 0);
			if (pick < 8) begin
				left  = $urandom();
				right = $urandom();
			end else if (pick < 11) begin
				left  = $urandom_range(1, 0) ? 24'h7F_FFFF : 24'h80_0000;
				right = $urandom_range(1, 0) ? 24'h7F_FFFF : 24'h80_0000;
			end else begin
				mag   = $urandom_range(amp, 0);
				left  = 24'($urandom_range(1, 0) ? -mag : mag);
				mag   = $urandom_range(amp, 0);
				right = 24'($urandom_range(1, 0) ? -mag : mag);
			end
			send_pair(left, right);
		end
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		src_idle_pct  = 6;
		sink_idle_pct = 77;

		// reset settings, full-scale and sign corners
		send_pair(24'h00_0000, 24'h00_0000);
		send_pair(24'h7F_FFFF, 24'h7F_FFFF);
		send_pair(24'h80_0000, 24'h80_0000);
		send_pair(24'h7F_FFFF, 24'h80_0000);
		send_pair(24'h80_0000, 24'h7F_FFFF);
		send_pair(24'h00_0001, 24'hFF_FFFF);
		send_pair(24'hFF_FFFF, 24'h00_0001);
		send_pair(24'hAA_AAAA, 24'h55_5555);
		drain();

		// coefficients, drop and mix above one; zero threshold
		write_reg(REG_THRESHOLD, 32'h0);
		write_reg(REG_OVER, 32'hFFFF_FFFF);
		write_reg(REG_ATTACK, 32'h1FF_FFFF);
		write_reg(REG_RELEASE, 32'h1FF_FFFF);
		write_reg(REG_DROP, 32'h1_FFFF);
		write_reg(REG_MIX, 32'h1_FFFF);
		send_pair(24'h7F_FFFF, 24'h00_0000);
		send_pair(24'h00_0000, 24'h80_0000);
		send_pair(24'h12_3456, 24'hFE_DCBA);
		send_pair(24'h00_0000, 24'h00_0000);
		send_pair(24'h40_0000, 24'hC0_0000);
		send_pair(24'h80_0000, 24'h80_0000);
		drain();

		// threshold above full scale, frozen followers, fully dry; unused indexes
		write_reg(REG_THRESHOLD, 32'hFF_FFFF);
		write_reg(REG_OVER, 32'h0);
		write_reg(REG_ATTACK, 32'h0);
		write_reg(REG_RELEASE, 32'h0);
		write_reg(REG_DROP, 32'h0);
		write_reg(REG_MIX, 32'h0);
		write_reg(REG_SPARE_A, $urandom());
		write_reg(REG_SPARE_B, $urandom());
		send_pair(24'h7F_FFFF, 24'h80_0000);
		send_pair(24'h00_0001, 24'hFF_FFFF);
		send_pair(24'h00_0000, 24'h00_0000);
		send_pair(24'h5A_5A5A, 24'hA5_A5A5);
		drain();

		// threshold exactly at full scale
		write_reg(REG_THRESHOLD, 32'h80_0000);
		write_reg(REG_OVER, 32'h1_0000);
		write_reg(REG_ATTACK, 32'h100_0000);
		write_reg(REG_DROP, 32'h1_0000);
		write_reg(REG_MIX, 32'h1_0000);
		send_pair(24'h80_0000, 24'h7F_FFFF);
		send_pair(24'h7F_FFFF, 24'h7F_FFFF);
		send_pair(24'h00_0000, 24'h00_0000);
		drain();

		for (int regime = 0; regime < 3; regime++) begin
			case (regime)
				0: begin
					src_idle_pct  = 6;
					sink_idle_pct = 77;
				end
				1: begin
					src_idle_pct  = 77;
					sink_idle_pct = 6;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			for (int seg = 0; seg < 4; seg++) begin
				pick_settings();
				// stall the output for a long while and keep offering pairs
				if (seg == 1 && regime != 1)
					hold_requests++;
				play_program(SEG_ITEMS);
				drain();
			end
		end

		repeat (SETTLE_TAIL) @(negedge clk);
		if (sb.errors == 0 && sb.ducked_due.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
